@@ src/steq_pkg.sv @@
// steq_pkg: shared widths, microcode word layout, control structs and the microcode program
// for the stereo tilt equalizer. No dependencies; every other file imports it.

package steq_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 16;
	localparam int SMP_W          = SAMPLE_BITS;
	localparam int FRAC_W         = COEF_FRAC_BITS;
	localparam int LP_W           = 32;
	localparam int A0_W           = 17;
	localparam int B1_W           = 18;
	localparam int GAIN_W         = 22;
	localparam int OG_W           = 21;

	// shared multiplier and accumulator
	localparam int A_W     = LP_W + 1;
	localparam int B_W     = GAIN_W;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = 62;
	localparam int R_W     = ACC_W - FRAC_W;
	localparam int T_W     = 40;
	localparam int T_SPLIT = T_W / 2;
	localparam int D_W     = LP_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_MONO      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A0        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B1        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN  = 3'd5;

	localparam logic [OG_W-1:0] OUT_GAIN_RESET = OG_W'(65536);

	// program layout
	localparam int N_STEPS = 12;
	localparam int STEP_W  = 4;

	typedef enum logic [2:0] {A_X, A_LP, A_L, A_D, A_TLO, A_THI} a_sel_t;
	typedef enum logic [2:0] {B_A0, B_B1, B_LG, B_HG, B_OG} b_sel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_HI} acc_op_t;
	typedef enum logic [2:0] {WB_NONE, WB_LP, WB_DIFF, WB_T, WB_OUT} wb_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    mul;
		acc_op_t acc_op;
		wb_t     wb;
		logic    last;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   adv;
		logic   load;
		logic   chan;
	} steq_ctrl_t;

	typedef struct packed {
		logic                     mono;
		logic [A0_W-1:0]          a0;
		logic signed [B1_W-1:0]   b1;
		logic signed [GAIN_W-1:0] lg;
		logic signed [GAIN_W-1:0] hg;
		logic [OG_W-1:0]          og;
	} steq_cfg_t;

	localparam uword_t UW_NOP = '{a_sel: A_X, b_sel: B_A0, mul: 1'b0, acc_op: ACC_HOLD,
		wb: WB_NONE, last: 1'b0};

	// per-channel program: low-pass, band reweight, output gain
	function automatic uword_t steq_ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = UW_NOP;
		case (step)
			4'd0: begin
				w.a_sel = A_X;   w.b_sel = B_A0; w.mul = 1'b1;
			end
			4'd1: begin
				w.a_sel = A_LP;  w.b_sel = B_B1; w.mul = 1'b1; w.acc_op = ACC_LOAD;
			end
			4'd2: w.acc_op = ACC_ADD;
			4'd3: w.wb = WB_LP;
			4'd4: begin
				w.a_sel = A_L;   w.b_sel = B_LG; w.mul = 1'b1; w.wb = WB_DIFF;
			end
			4'd5: begin
				w.a_sel = A_D;   w.b_sel = B_HG; w.mul = 1'b1; w.acc_op = ACC_LOAD;
			end
			4'd6: w.acc_op = ACC_ADD;
			4'd7: w.wb = WB_T;
			4'd8: begin
				w.a_sel = A_TLO; w.b_sel = B_OG; w.mul = 1'b1;
			end
			4'd9: begin
				w.a_sel = A_THI; w.b_sel = B_OG; w.mul = 1'b1; w.acc_op = ACC_LOAD;
			end
			4'd10: w.acc_op = ACC_ADD_HI;
			4'd11: begin
				w.wb = WB_OUT;   w.last = 1'b1;
			end
			default: w = UW_NOP;
		endcase
		return w;
	endfunction

	// clamp a rounded value to the filter state range
	function automatic logic signed [LP_W-1:0] sat_lp(input logic signed [R_W-1:0] v);
		logic same;
		same = (&v[R_W-1:LP_W-1]) | ~(|v[R_W-1:LP_W-1]);
		if (same)
			return v[LP_W-1:0];
		else if (v[R_W-1])
			return {1'b1, {(LP_W-1){1'b0}}};
		else
			return {1'b0, {(LP_W-1){1'b1}}};
	endfunction

	// clamp a rounded value to the sample range
	function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [R_W-1:0] v);
		logic same;
		same = (&v[R_W-1:SMP_W-1]) | ~(|v[R_W-1:SMP_W-1]);
		if (same)
			return v[SMP_W-1:0];
		else if (v[R_W-1])
			return {1'b1, {(SMP_W-1){1'b0}}};
		else
			return {1'b0, {(SMP_W-1){1'b1}}};
	endfunction

endpackage

@@ src/steq_ifs.sv @@
// steq_ifs: valid/ready channel interfaces for samples in, results out and register writes.
// Depends on steq_pkg for widths.

interface steq_in_if import steq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] left_in;
	logic signed [SMP_W-1:0] right_in;
	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface steq_out_if import steq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] left_out;
	logic signed [SMP_W-1:0] right_out;
	modport source(output valid, output left_out, output right_out, input ready);
	modport sink(input valid, input left_out, input right_out, output ready);
endinterface

interface steq_cfg_if import steq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ src/steq_sequencer.sv @@
// steq_sequencer: step counter, channel select and handshakes; reads the microcode program
// from steq_pkg and hands one control word per cycle to the datapath while it is not stalled.

module steq_sequencer import steq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic       mono,
	output steq_ctrl_t ctrl
);

	typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_RUN = 2'b10} seq_state_t;

	seq_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic              chan_q;
	logic              out_valid_q;
	uword_t            uw;
	logic              last_chan;
	logic              stall;
	logic              adv;
	logic              load;

	// current control word and stall on a full result register
	always_comb begin
		uw        = steq_ucode(step_q);
		last_chan = mono | chan_q;
		stall     = uw.last & last_chan & out_valid_q & ~out_ready;
		adv       = (state_q == ST_RUN) & ~stall;
		in_ready  = (state_q == ST_IDLE);
		load      = in_valid & in_ready;
	end

	assign out_valid = out_valid_q;
	assign ctrl      = '{uw: uw, adv: adv, load: load, chan: chan_q};

	// step counter and channel walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			chan_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						chan_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (uw.last) begin
							step_q <= '0;
							if (last_chan)
								state_q <= ST_IDLE;
							else
								chan_q <= 1'b1;
						end else begin
							step_q <= step_q + STEP_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && uw.last && last_chan) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/steq_datapath.sv @@
// steq_datapath: shared multiplier, accumulator with rounding and saturation, filter states
// and result registers, all steered by the control word from steq_sequencer (steq_pkg).

module steq_datapath import steq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  steq_ctrl_t              ctrl,
	input  steq_cfg_t               cfg,
	input  logic signed [SMP_W-1:0] left_in,
	input  logic signed [SMP_W-1:0] right_in,
	output logic signed [SMP_W-1:0] left_out,
	output logic signed [SMP_W-1:0] right_out
);

	logic signed [SMP_W-1:0] xl_q, xr_q;
	logic signed [LP_W-1:0]  lpl_q, lpr_q;
	logic signed [LP_W-1:0]  l_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [T_W-1:0]   t_q;
	logic signed [P_W-1:0]   prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SMP_W-1:0] yl_q;
	logic signed [SMP_W-1:0] out_l_q, out_r_q;

	logic signed [SMP_W:0]   pair_sum;
	logic signed [SMP_W-1:0] x_cur;
	logic signed [LP_W-1:0]  lp_cur;
	logic signed [A_W-1:0]   a_op;
	logic signed [B_W-1:0]   b_op;
	logic signed [P_W-1:0]   prod;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] prod_hi;
	logic signed [ACC_W-1:0] rsum;
	logic signed [R_W-1:0]   rnd_v;
	logic signed [LP_W-1:0]  l_new;
	logic signed [SMP_W-1:0] y_new;
	logic signed [T_W-1:0]   t_new;
	logic signed [D_W-1:0]   d_new;

	// operand selection for the shared multiplier
	always_comb begin
		pair_sum = {left_in[SMP_W-1], left_in} + {right_in[SMP_W-1], right_in};
		x_cur    = ctrl.chan ? xr_q : xl_q;
		lp_cur   = ctrl.chan ? lpr_q : lpl_q;
		case (ctrl.uw.a_sel)
			A_X:     a_op = {{(A_W-SMP_W){x_cur[SMP_W-1]}}, x_cur};
			A_LP:    a_op = {{(A_W-LP_W){lp_cur[LP_W-1]}}, lp_cur};
			A_L:     a_op = {{(A_W-LP_W){l_q[LP_W-1]}}, l_q};
			A_D:     a_op = d_q;
			A_TLO:   a_op = {{(A_W-T_SPLIT){1'b0}}, t_q[T_SPLIT-1:0]};
			A_THI:   a_op = {{(A_W-T_W+T_SPLIT){t_q[T_W-1]}}, t_q[T_W-1:T_SPLIT]};
			default: a_op = '0;
		endcase
		case (ctrl.uw.b_sel)
			B_A0:    b_op = {{(B_W-A0_W){1'b0}}, cfg.a0};
			B_B1:    b_op = {{(B_W-B1_W){cfg.b1[B1_W-1]}}, cfg.b1};
			B_LG:    b_op = cfg.lg;
			B_HG:    b_op = cfg.hg;
			B_OG:    b_op = {{(B_W-OG_W){1'b0}}, cfg.og};
			default: b_op = '0;
		endcase
		prod = a_op * b_op;
	end

	// accumulate, round, saturate
	always_comb begin
		prod_ext = {{(ACC_W-P_W){prod_q[P_W-1]}}, prod_q};
		prod_hi  = prod_ext <<< T_SPLIT;
		rsum     = acc_q + ACC_W'(1 << (FRAC_W - 1));
		rnd_v    = rsum[ACC_W-1:FRAC_W];
		l_new    = sat_lp(rnd_v);
		y_new    = sat_smp(rnd_v);
		t_new    = {{(T_W-SMP_W){x_cur[SMP_W-1]}}, x_cur} + rnd_v[T_W-1:0];
		d_new    = {{(D_W-SMP_W){x_cur[SMP_W-1]}}, x_cur} - {l_q[LP_W-1], l_q};
	end

	// sample capture; mono mode keeps the floored average in the left slot
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			xl_q <= cfg.mono ? pair_sum[SMP_W:1] : left_in;
			xr_q <= right_in;
		end
	end

	// multiplier output register and accumulator
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			if (ctrl.uw.mul)
				prod_q <= prod;
			case (ctrl.uw.acc_op)
				ACC_LOAD:   acc_q <= prod_ext;
				ACC_ADD:    acc_q <= acc_q + prod_ext;
				ACC_ADD_HI: acc_q <= acc_q + prod_hi;
				default:    acc_q <= acc_q;
			endcase
		end
	end

	// scratch registers and results
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			case (ctrl.uw.wb)
				WB_LP:   l_q <= l_new;
				WB_DIFF: d_q <= d_new;
				WB_T:    t_q <= t_new;
				WB_OUT: begin
					if (!ctrl.chan && !cfg.mono) begin
						yl_q <= y_new;
					end else begin
						out_l_q <= cfg.mono ? y_new : yl_q;
						out_r_q <= y_new;
					end
				end
				default: ;
			endcase
		end
	end

	// filter states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpl_q <= '0;
			lpr_q <= '0;
		end else if (ctrl.adv && ctrl.uw.wb == WB_LP) begin
			if (ctrl.chan)
				lpr_q <= l_new;
			else
				lpl_q <= l_new;
		end
	end

	assign left_out  = out_l_q;
	assign right_out = out_r_q;

endmodule

@@ src/stereo_tilt_equalizer.sv @@
// Stereo tilt equalizer: each channel runs a one-pole low-pass and the split is reweighted
// as x + low_gain*lp + high_gain*(x - lp), then scaled by the output gain and saturated to
// 24 bits. Mono mode averages both inputs through the left filter and sends the same result
// to both outputs. Coefficients are Q.16 and are written through cfg (index 0 mono, 1 low-pass
// input weight, 2 feedback weight, 3 low gain, 4 high gain, 5 output gain); write them only
// while the block is idle. One 33x22 multiplier is shared by a 12-step microcode program per
// channel, so a stereo pair runs it twice, a mono item once; the sample port is ready in the
// cycle after the last step. A finished result waits in an output register and the next
// request is taken meanwhile; work stalls on its last step only if that register is full.
// Depends on steq_pkg, steq_ifs, steq_sequencer and steq_datapath.

module stereo_tilt_equalizer import steq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	steq_cfg_if.sink    cfg,
	steq_in_if.sink     sample,
	steq_out_if.source  result
);

	steq_cfg_t  cfg_q;
	steq_ctrl_t ctrl;

	// configuration registers, writes to unused indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mono <= 1'b0;
			cfg_q.a0   <= '0;
			cfg_q.b1   <= '0;
			cfg_q.lg   <= '0;
			cfg_q.hg   <= '0;
			cfg_q.og   <= OUT_GAIN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MONO:      cfg_q.mono <= cfg.data[0];
				REG_A0:        cfg_q.a0   <= cfg.data[A0_W-1:0];
				REG_B1:        cfg_q.b1   <= cfg.data[B1_W-1:0];
				REG_LOW_GAIN:  cfg_q.lg   <= cfg.data[GAIN_W-1:0];
				REG_HIGH_GAIN: cfg_q.hg   <= cfg.data[GAIN_W-1:0];
				REG_OUT_GAIN:  cfg_q.og   <= cfg.data[OG_W-1:0];
				default: ;
			endcase
		end
	end

	// microcode sequencer
	steq_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.mono      (cfg_q.mono),
		.ctrl      (ctrl)
	);

	// arithmetic datapath
	steq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.left_in   (sample.left_in),
		.right_in  (sample.right_in),
		.left_out  (result.left_out),
		.right_out (result.right_out)
	);

endmodule

@@ test/tb_stereo_tilt_equalizer.sv @@
`timescale 1ns / 1ps
// tb_stereo_tilt_equalizer: self-checking bench for the stereo tilt equalizer, a directed
// table followed by randomized coefficient sets, results checked against a local model or
// typed table values. Depends on steq_pkg, steq_ifs and the stereo_tilt_equalizer RTL.

module tb_stereo_tilt_equalizer import steq_pkg::*; ();

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 40;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 1026;
	localparam int FINAL_STRETCH = 150;
	localparam int HOLD_AT       = 15;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic signed [SMP_W-1:0] MAX_SMP = 24'sh7FFFFF;
	localparam logic signed [SMP_W-1:0] MIN_SMP = 24'sh800000;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_smp;
		logic signed [SMP_W-1:0] right_smp;
	} stereo_t;

	typedef enum {ROW_WRITE, ROW_PAIR} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
		logic signed [SMP_W-1:0] l;
		logic signed [SMP_W-1:0] r;
		bit                      typed;
		stereo_t                 want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	steq_cfg_if cfg_ch ();
	steq_in_if  smp_ch ();
	steq_out_if res_ch ();

	stereo_tilt_equalizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.sample (smp_ch.sink),
		.result (res_ch.source)
	);

	// equalizer model state and coefficients
	bit     eq_mono;
	longint eq_a0, eq_b1, eq_lg, eq_hg, eq_og;
	longint left_lp, right_lp;

	stereo_t   pending[$];
	plan_row_t plan[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        src_idle_en = 1'b1;
	bit        snk_idle_en = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// round to nearest, ties toward plus infinity, drop the Q.16 fraction
	function automatic longint q16_round(input longint v);
		return (v + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
	endfunction

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic longint lowpass_next(input longint x, input longint lp);
		return clamp(q16_round(eq_a0 * x + eq_b1 * lp), LP_W);
	endfunction

	// band reweight, then output gain
	function automatic longint band_out(input longint x, input longint l);
		longint t;
		t = x + q16_round(eq_lg * l + eq_hg * (x - l));
		return clamp(q16_round(t * eq_og), SMP_W);
	endfunction

	function automatic stereo_t equalize_pair(input logic signed [SMP_W-1:0] l,
		input logic signed [SMP_W-1:0] r);
		stereo_t res;
		longint  x;
		longint  y;
		if (eq_mono) begin
			// floor average, right filter untouched
			x = (longint'(l) + longint'(r)) >>> 1;
			left_lp = lowpass_next(x, left_lp);
			y = band_out(x, left_lp);
			res.left_smp = y[SMP_W-1:0];
			res.right_smp = y[SMP_W-1:0];
		end else begin
			left_lp = lowpass_next(longint'(l), left_lp);
			y = band_out(longint'(l), left_lp);
			res.left_smp = y[SMP_W-1:0];
			right_lp = lowpass_next(longint'(r), right_lp);
			y = band_out(longint'(r), right_lp);
			res.right_smp = y[SMP_W-1:0];
		end
		return res;
	endfunction

	// keep the register width, sign-extend the signed ones, ignore unknown indexes
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_MONO:      eq_mono = d[0];
			REG_A0:        eq_a0 = longint'(d[A0_W-1:0]);
			REG_B1:        eq_b1 = longint'($signed(d[B1_W-1:0]));
			REG_LOW_GAIN:  eq_lg = longint'($signed(d[GAIN_W-1:0]));
			REG_HIGH_GAIN: eq_hg = longint'($signed(d[GAIN_W-1:0]));
			REG_OUT_GAIN:  eq_og = longint'(d[OG_W-1:0]);
			default: ;
		endcase
	endfunction

	function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		plan_row_t row;
		row.kind = ROW_WRITE;
		row.index = idx;
		row.data = d;
		row.l = '0;
		row.r = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_pair(input logic signed [SMP_W-1:0] l,
		input logic signed [SMP_W-1:0] r, input bit typed,
		input logic signed [SMP_W-1:0] el, input logic signed [SMP_W-1:0] er);
		plan_row_t row;
		row.kind = ROW_PAIR;
		row.index = '0;
		row.data = '0;
		row.l = l;
		row.r = r;
		row.typed = typed;
		row.want.left_smp = el;
		row.want.right_smp = er;
		plan.push_back(row);
	endfunction

	function automatic int pick_in(input int lo, input int hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 15))
			0: return MAX_SMP;
			1: return MIN_SMP;
			2, 3: return SMP_W'(int'($urandom_range(0, 512)) - 256);
			default: return SMP_W'($urandom());
		endcase
	endfunction

	function automatic int rand_gain();
		if ($urandom_range(0, 1))
			return pick_in(-65536, 131072);
		return pick_in(-65536, 1179648);
	endfunction

	// one sample request; the expectation is queued once it is taken
	task automatic offer_pair(input logic signed [SMP_W-1:0] l,
		input logic signed [SMP_W-1:0] r, input bit typed, input stereo_t want);
		stereo_t due;
		cfg_ch.valid <= 1'b0;
		smp_ch.valid <= 1'b1;
		smp_ch.left_in <= l;
		smp_ch.right_in <= r;
		do @(posedge clk); while (smp_ch.ready !== 1'b1);
		due = equalize_pair(l, r);
		if (typed)
			due = want;
		pending.push_back(due);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			smp_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// leaves valid high so writes can go back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		apply_reg(idx, d);
	endtask

	// stop sending and let every outstanding request come back
	task automatic wait_idle();
		smp_ch.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// fresh coefficient set between random bursts
	task automatic retune();
		int a0v;
		int b1v;
		wait_idle();
		case ($urandom_range(0, 2))
			0: begin
				b1v = $urandom_range(0, 65536);
				a0v = 65536 - b1v;
			end
			1: begin
				b1v = pick_in(-65536, 65536);
				a0v = pick_in(0, 131071);
			end
			default: begin
				b1v = $urandom_range(0, 1) ? 65536 : -65536;
				a0v = $urandom_range(0, 1) ? 131071 : 0;
			end
		endcase
		write_reg(REG_MONO, CFG_DATA_W'($urandom_range(0, 3) == 0));
		write_reg(REG_A0, CFG_DATA_W'(a0v));
		write_reg(REG_B1, CFG_DATA_W'(b1v));
		write_reg(REG_LOW_GAIN, CFG_DATA_W'(rand_gain()));
		write_reg(REG_HIGH_GAIN, CFG_DATA_W'(rand_gain()));
		if ($urandom_range(0, 1))
			write_reg(REG_OUT_GAIN, CFG_DATA_W'(pick_in(32768, 131072)));
		else
			write_reg(REG_OUT_GAIN, CFG_DATA_W'(pick_in(0, 1245184)));
	endtask

	// run limit
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// result side: compare against the oldest expectation, stall in bursts
	initial begin : result_sink
		int      stall_left;
		int      got;
		stereo_t due;
		stall_left = 0;
		got = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got++;
				if (pending.size() == 0) begin
					fail_count++;
					$error("result with no request pending: left_out %0d right_out %0d",
						res_ch.left_out, res_ch.right_out);
				end else begin
					due = pending.pop_front();
					if (res_ch.left_out !== due.left_smp) begin
						fail_count++;
						$error("left_out: expected %0d, got %0d", $signed(due.left_smp),
							res_ch.left_out);
					end
					if (res_ch.right_out !== due.right_smp) begin
						fail_count++;
						$error("right_out: expected %0d, got %0d", $signed(due.right_smp),
							res_ch.right_out);
					end
				end
				// one long hold so the block backs up into its input
				if (got == HOLD_AT)
					stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		bit last_write;
		int sent;
		int remaining;
		int burst;

		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		smp_ch.valid <= 1'b0;
		smp_ch.left_in <= '0;
		smp_ch.right_in <= '0;

		eq_mono = 1'b0;
		eq_a0 = 0;
		eq_b1 = 0;
		eq_lg = 0;
		eq_hg = 0;
		eq_og = longint'(OUT_GAIN_RESET);
		left_lp = 0;
		right_lp = 0;

		// reset values: filter off, unity gain, output follows input
		plan_pair(24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0);
		plan_pair(MAX_SMP, MIN_SMP, 1'b1, MAX_SMP, MIN_SMP);
		plan_pair(MIN_SMP, MAX_SMP, 1'b1, MIN_SMP, MAX_SMP);
		plan_pair(24'sd1, -24'sd1, 1'b1, 24'sd1, -24'sd1);
		// zero output gain
		plan_write(REG_OUT_GAIN, CFG_DATA_W'(0));
		plan_pair(MAX_SMP, MIN_SMP, 1'b1, 24'sd0, 24'sd0);
		// output gain of 19, junk above the register width, output saturation
		plan_write(REG_OUT_GAIN, CFG_DATA_W'((1 << OG_W) | 1245184));
		plan_pair(MAX_SMP, MIN_SMP, 1'b1, MAX_SMP, MIN_SMP);
		plan_pair(24'sd1, -24'sd1, 1'b1, 24'sd19, -24'sd19);
		// mono average rounds down; unknown index is dropped
		plan_write(REG_OUT_GAIN, CFG_DATA_W'(OUT_GAIN_RESET));
		plan_write(REG_MONO, CFG_DATA_W'(22'h3FFFFF));
		plan_write(REG_UNUSED, CFG_DATA_W'(22'h2AAAAA));
		plan_pair(MAX_SMP, MIN_SMP, 1'b1, -24'sd1, -24'sd1);
		plan_pair(24'sd3, 24'sd4, 1'b1, 24'sd3, 24'sd3);
		plan_pair(-24'sd3, -24'sd4, 1'b1, -24'sd4, -24'sd4);
		plan_pair(MAX_SMP, MAX_SMP, 1'b1, MAX_SMP, MAX_SMP);
		// half-weight low-pass hits rounding ties
		plan_write(REG_MONO, CFG_DATA_W'(22'h3FFFFE));
		plan_write(REG_A0, CFG_DATA_W'(22'h3E8000));
		plan_write(REG_LOW_GAIN, CFG_DATA_W'(65536));
		plan_pair(24'sd1, -24'sd1, 1'b0, '0, '0);
		plan_pair(-24'sd1, 24'sd1, 1'b0, '0, '0);
		// runaway filter: state saturates, gains at their extremes
		plan_write(REG_A0, CFG_DATA_W'(131071));
		plan_write(REG_B1, CFG_DATA_W'(65536));
		plan_write(REG_LOW_GAIN, CFG_DATA_W'(1179648));
		plan_write(REG_HIGH_GAIN, CFG_DATA_W'(-65536));
		plan_write(REG_OUT_GAIN, CFG_DATA_W'(1245184));
		repeat (8) plan_pair(MAX_SMP, MIN_SMP, 1'b0, '0, '0);
		plan_write(REG_B1, CFG_DATA_W'(-65536));
		plan_write(REG_LOW_GAIN, CFG_DATA_W'(-65536));
		plan_write(REG_HIGH_GAIN, CFG_DATA_W'(1179648));
		repeat (3) plan_pair(MIN_SMP, MAX_SMP, 1'b0, '0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		last_write = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!last_write)
					wait_idle();
				write_reg(plan[i].index, plan[i].data);
				last_write = 1'b1;
			end else begin
				offer_pair(plan[i].l, plan[i].r, plan[i].typed, plan[i].want);
				last_write = 1'b0;
			end
		end

		// random bursts, each under its own coefficient set; no idling at the end
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			remaining = RANDOM_ITEMS - sent;
			if (remaining <= FINAL_STRETCH) begin
				burst = remaining;
				src_idle_en = 1'b0;
				snk_idle_en = 1'b0;
			end else begin
				burst = $urandom_range(60, 140);
				if (burst > remaining - FINAL_STRETCH)
					burst = remaining - FINAL_STRETCH;
				src_idle_en = $urandom_range(0, 3) != 0;
				snk_idle_en = $urandom_range(0, 3) != 0;
			end
			retune();
			repeat (burst) offer_pair(rand_sample(), rand_sample(), 1'b0, '0);
			sent += burst;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
